// ===== rtl/core/prpd_pkg.sv =====
// prpd_pkg: shared types and constants of the pulse rate peak detector
// used by every module in rtl/core, depends on nothing

package prpd_pkg;

	localparam int unsigned NUM_REGS = 7;
	localparam int unsigned CFG_BITS = 23;
	localparam int unsigned IDX_BITS = 3;

	localparam logic [IDX_BITS-1:0] REG_AMP_ON     = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_AMP_OFF    = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_HOLD_ON    = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_HOLD_OFF   = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_WARMUP     = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_MIN_INT    = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_START_THR  = 3'd6;

	localparam logic [1:0] ST_NO_FINGER = 2'd0;
	localparam logic [1:0] ST_WARMING   = 2'd1;
	localparam logic [1:0] ST_NO_RATE   = 2'd2;
	localparam logic [1:0] ST_RATE      = 2'd3;

	localparam logic [31:0] RATE_NUM   = 32'd15360000;
	localparam int unsigned IGNORE_MAX = 3;

	typedef struct packed {
		logic        load;
		logic [15:0] value;
	} prpd_cell_in_t;

endpackage

// ===== rtl/core/pulse_rate_peak_detector_core.sv =====
// pulse_rate_peak_detector_core: top level of the pulse rate peak detector
// depends on prpd_pkg, prpd_median and prpd_divider
//
// Usage: samples enter on the in channel (ac_sample, time_ms) with
// in_valid/in_ready; one result word per sample leaves on the out channel
// (status, rate_bpm, finger_present) with out_valid/out_ready.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, the block itself does not enforce it.
// A sample that gives no new rate passes S_AMP_HI and S_AMP_LO (the
// amplitude average divide by 20) and S_STEP before out_valid. A sample
// with a peak and a full interval history goes on through S_SORT (load of
// the sort cells), S_MED (the median sort chain), S_DIV (the bit-serial
// divider) and S_RATE. One sample is worked on at a time, so a new word
// is taken only after the previous result word has been taken.
// Reset clears all state but the interval history and loads register
// defaults; history entries are filled before they are read. When the
// receiver stalls the result word holds in the output register and
// in_ready stays low until taken.

module pulse_rate_peak_detector_core #(
	parameter int unsigned HISTORY_DEPTH = 7,
	parameter int unsigned SAMPLE_BITS   = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] ac_sample,
	input  logic [31:0]                   time_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [7:0]                    rate_bpm,
	output logic                          finger_present,
	input  logic                          cfg_we,
	input  logic [prpd_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [prpd_pkg::CFG_BITS-1:0] cfg_data
);
	import prpd_pkg::*;

	localparam int unsigned AB = SAMPLE_BITS + 8;
	localparam int unsigned PB = (SAMPLE_BITS + 2 > 26) ? SAMPLE_BITS + 2 : 26;
	localparam int unsigned HCW = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned NB = AB + 2;
	localparam int unsigned LB = NB / 2;
	localparam int unsigned CB = LB + 3;
	localparam int unsigned KB = CB + 2;
	localparam logic [KB-1:0] RECIP5_AMP = KB'(((64'd1 << KB) + 64'd4) / 64'd5);
	localparam logic [18:0] RECIP5_Q21 = 19'd419431;

	typedef enum logic [3:0] {
		S_IDLE, S_AMP_HI, S_AMP_LO, S_STEP, S_SORT, S_MED, S_DIV, S_RATE, S_OUT
	} state_t;

	state_t state_q;

	logic [22:0] amp_on_q, amp_off_q, start_thr_q;
	logic [15:0] hold_on_q, hold_off_q, warmup_q, min_int_q;

	logic [AB-1:0]            amp_avg_q;
	logic                     finger_q, hold_cnt_q, seeking_q, last_valid_q, ravg_valid_q;
	logic [31:0]              hold_start_q, finger_on_q, last_time_q;
	logic signed [PB-1:0]     peak_level_q;
	logic signed [SAMPLE_BITS-1:0] prev_q, cand_q, x_q;
	logic [31:0]              now_q;
	logic [1:0]               ign_q;
	logic [HCW-1:0]           icnt_q;
	logic [15:0]              hist_q [HISTORY_DEPTH];
	logic [15:0]              ravg_q;
	logic [1:0]               status_q;
	logic [7:0]               rate_q;
	logic [NB-1:0]            n_s1;
	logic [CB-1:0]            qh_s2;

	// floor(n/5) for n below 2^CB
	function automatic logic [CB-1:0] div5(input logic [CB-1:0] n);
		logic [CB+KB-1:0] p;
		p = (CB+KB)'(n) * (CB+KB)'(RECIP5_AMP);
		return CB'(p >> KB);
	endfunction

	// amplitude average stage, divide by 20 as a shift and two chunks by 5
	logic [SAMPLE_BITS-1:0] absx;
	logic [AB+5:0]          amp_sum;
	logic [CB-1:0]          amp_hi, amp_rem, amp_lo;
	logic [AB-1:0]          amp_div;
	assign absx    = ac_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-ac_sample) : ac_sample;
	assign amp_sum = (AB+6)'(amp_avg_q) * (AB+6)'(19) + ((AB+6)'(absx) << 8) + (AB+6)'(10);
	assign amp_hi  = CB'(n_s1[NB-1:LB]);
	assign amp_rem = amp_hi - qh_s2 * CB'(5);
	assign amp_lo  = {amp_rem[2:0], n_s1[LB-1:0]};
	assign amp_div = AB'({qh_s2, {LB{1'b0}}} + (CB+LB)'(div5(amp_lo)));

	// sequential step logic on registered sample
	logic [HISTORY_DEPTH*16-1:0] hist_flat;
	logic med_start, med_done, div_start, div_done;
	logic [15:0] median;
	logic [31:0] quotient;

	always_comb begin
		for (int i = 0; i < HISTORY_DEPTH; i++) hist_flat[i*16 +: 16] = hist_q[i];
	end

	prpd_median #(.DEPTH(HISTORY_DEPTH)) u_median (
		.clk(clk), .arst_n(arst_n), .start(med_start), .hist(hist_flat),
		.done(med_done), .median(median)
	);

	logic [15:0] m1;
	assign m1 = (median == 16'd0) ? 16'd1 : median;

	prpd_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(RATE_NUM + 32'(m1[15:1])), .divisor(m1),
		.done(div_done), .quotient(quotient)
	);

	assign med_start = (state_q == S_SORT);
	assign div_start = (state_q == S_MED) && med_done;

	// combinational view of one step after amplitude update
	logic        f_n, hc_n, sk_n, lv_n, rv_n, step_rate;
	logic [31:0] hs_n, fo_n, lt_n;
	logic signed [PB-1:0] pl_n;
	logic signed [SAMPLE_BITS-1:0] pv_n, cd_n;
	logic [1:0]  ig_n, st_n;
	logic [HCW-1:0] ic_n;
	logic        push;
	logic [15:0] push_v;
	logic [31:0] dt;

	function automatic logic ign_q_lt(input logic [1:0] c);
		return c < 2'(IGNORE_MAX);
	endfunction

	always_comb begin
		f_n = finger_q; hc_n = hold_cnt_q; hs_n = hold_start_q; fo_n = finger_on_q;
		sk_n = seeking_q; pl_n = peak_level_q; pv_n = prev_q; cd_n = cand_q;
		lt_n = last_time_q; lv_n = last_valid_q; ig_n = ign_q; ic_n = icnt_q;
		rv_n = ravg_valid_q; st_n = ST_NO_RATE; push = 1'b0; push_v = '0;
		step_rate = 1'b0; dt = '0;
		if (!finger_q) begin
			if (64'(amp_avg_q) > (64'(amp_on_q) << 8)) begin
				if (!hc_n) begin hc_n = 1'b1; hs_n = now_q; end
				if ((now_q - hs_n) >= 32'(hold_on_q)) begin
					f_n = 1'b1; fo_n = now_q; pv_n = '0;
					hc_n = 1'b0; hs_n = '0; sk_n = 1'b1;
					pl_n = PB'({start_thr_q, 2'b00}); lt_n = '0; lv_n = 1'b0;
					ig_n = '0; ic_n = '0; rv_n = 1'b0;
				end
			end else hc_n = 1'b0;
		end else begin
			if (64'(amp_avg_q) < (64'(amp_off_q) << 8)) begin
				if (!hc_n) begin hc_n = 1'b1; hs_n = now_q; end
				if ((now_q - hs_n) >= 32'(hold_off_q)) begin
					f_n = 1'b0;
					hc_n = 1'b0; hs_n = '0; sk_n = 1'b1;
					pl_n = PB'({start_thr_q, 2'b00}); lt_n = '0; lv_n = 1'b0;
					ig_n = '0; ic_n = '0; rv_n = 1'b0;
				end
			end else hc_n = 1'b0;
		end
		if (!f_n) begin
			st_n = ST_NO_FINGER;
		end else if ((now_q - fo_n) < 32'(warmup_q)) begin
			st_n = ST_WARMING;
		end else begin
			if (sk_n && ($signed({x_q, 2'b00}) > pl_n) && (pv_n < x_q)) begin
				cd_n = x_q; sk_n = 1'b0;
			end
			if (!sk_n && (x_q < pv_n)) begin
				dt = lv_n ? (now_q - lt_n) : 32'd0;
				sk_n = 1'b1;
				if (lv_n && (dt < 32'(min_int_q))) begin
					st_n = ST_WARMING;
				end else begin
					lt_n = now_q; lv_n = 1'b1;
					pl_n = (PB'(cd_n) < PB'(30 * 1024)) ? PB'(30 * 1024) : PB'(cd_n);
					if (ign_q_lt(ig_n)) begin
						ig_n = ig_n + 2'd1; st_n = ST_WARMING;
					end else begin
						if (dt != 32'd0) begin
							push = 1'b1;
							push_v = (dt > 32'd65535) ? 16'hFFFF : dt[15:0];
							if (ic_n < HCW'(HISTORY_DEPTH)) ic_n = ic_n + 1'b1;
						end
						if (ic_n >= HCW'(HISTORY_DEPTH)) step_rate = 1'b1;
					end
				end
			end
		end
	end

	// rate average, divide by 10 as a shift and a reciprocal multiply
	logic [31:0] r_sat;
	logic [19:0] ravg_sum;
	logic [37:0] ravg_prod;
	logic [15:0] ravg_new;
	logic [8:0]  q9;
	assign r_sat     = (quotient > 32'd65535) ? 32'd65535 : quotient;
	assign ravg_sum  = 20'(ravg_q) * 20'd7 + 20'(r_sat[15:0]) * 20'd3 + 20'd5;
	assign ravg_prod = 38'(ravg_sum[19:1]) * 38'(RECIP5_Q21);
	assign ravg_new  = ravg_valid_q ? ravg_prod[36:21] : r_sat[15:0];
	assign q9        = 9'(({1'b0, ravg_new} + 17'd128) >> 8);

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_on_q <= 23'd12800; amp_off_q <= 23'd5120; hold_on_q <= 16'd500;
			hold_off_q <= 16'd500; warmup_q <= 16'd2000; min_int_q <= 16'd300;
			start_thr_q <= 23'd7680;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AMP_ON:    amp_on_q    <= cfg_data;
				REG_AMP_OFF:   amp_off_q   <= cfg_data;
				REG_HOLD_ON:   hold_on_q   <= cfg_data[15:0];
				REG_HOLD_OFF:  hold_off_q  <= cfg_data[15:0];
				REG_WARMUP:    warmup_q    <= cfg_data[15:0];
				REG_MIN_INT:   min_int_q   <= cfg_data[15:0];
				REG_START_THR: start_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_STEP && push) begin
			if (icnt_q < HCW'(HISTORY_DEPTH)) begin
				hist_q[icnt_q] <= push_v;
			end else begin
				for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist_q[i] <= hist_q[i+1];
				hist_q[HISTORY_DEPTH-1] <= push_v;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			amp_avg_q <= '0; finger_q <= 1'b0; hold_cnt_q <= 1'b0; hold_start_q <= '0;
			finger_on_q <= '0; seeking_q <= 1'b1; peak_level_q <= PB'(7680 * 4);
			prev_q <= '0; cand_q <= '0; last_time_q <= '0; last_valid_q <= 1'b0;
			ign_q <= '0; icnt_q <= '0; ravg_q <= '0; ravg_valid_q <= 1'b0;
			status_q <= ST_NO_FINGER; rate_q <= '0; out_valid <= 1'b0;
			x_q <= '0; now_q <= '0; n_s1 <= '0; qh_s2 <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						n_s1 <= amp_sum[AB+3:2];
						x_q <= ac_sample; now_q <= time_ms;
						state_q <= S_AMP_HI;
					end
				end
				S_AMP_HI: begin
					qh_s2 <= div5(amp_hi);
					state_q <= S_AMP_LO;
				end
				S_AMP_LO: begin
					amp_avg_q <= amp_div;
					state_q <= S_STEP;
				end
				S_STEP: begin
					finger_q <= f_n; hold_cnt_q <= hc_n; hold_start_q <= hs_n;
					finger_on_q <= fo_n; seeking_q <= sk_n; peak_level_q <= pl_n;
					cand_q <= cd_n; last_time_q <= lt_n; last_valid_q <= lv_n;
					ign_q <= ig_n; icnt_q <= ic_n; prev_q <= x_q;
					if (!rv_n) begin ravg_valid_q <= 1'b0; ravg_q <= '0; end
					status_q <= st_n; rate_q <= '0;
					if (step_rate) state_q <= S_SORT;
					else begin out_valid <= 1'b1; state_q <= S_OUT; end
				end
				S_SORT: begin
					state_q <= S_MED;
				end
				S_MED: begin
					if (med_done) state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) state_q <= S_RATE;
				end
				S_RATE: begin
					ravg_q <= ravg_new; ravg_valid_q <= 1'b1;
					rate_q <= q9[8] ? 8'hFF : q9[7:0];
					status_q <= ST_RATE; out_valid <= 1'b1; state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin out_valid <= 1'b0; state_q <= S_IDLE; end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign status         = status_q;
	assign rate_bpm       = rate_q;
	assign finger_present = finger_q;

	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while word pending");
	a_rate_only_on3: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_q != ST_RATE) |-> rate_q == 8'd0)
		else $error("rate without valid status");
	a_nofinger: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !finger_q) |-> status_q == ST_NO_FINGER)
		else $error("status disagrees with finger flag");
endmodule

// ===== rtl/core/prpd_sort_cell.sv =====
// prpd_sort_cell: one cell of the sorting chain for the interval median
// depends on prpd_pkg

module prpd_sort_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [15:0] load_val,
	input  logic        step,
	input  logic        odd_phase,
	input  logic        pair_lo,
	input  logic [15:0] left_val,
	input  logic [15:0] right_val,
	input  logic        has_left,
	input  logic        has_right,
	output logic [15:0] val
);
	import prpd_pkg::*;

	logic [15:0] val_q;
	logic        lower;

	// pair parity: pair_lo is the lower side in even phases, lower in this phase
	assign lower = pair_lo ^ odd_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (load) begin
			val_q <= load_val;
		end else if (step) begin
			if (lower && has_right) begin
				if (val_q > right_val) val_q <= right_val;
			end else if (!lower && has_left) begin
				if (left_val > val_q) val_q <= left_val;
			end
		end
	end

	assign val = val_q;
endmodule

// ===== rtl/core/prpd_median.sv =====
// prpd_median: odd-even transposition sort over a row of sort cells
// depends on prpd_pkg and prpd_sort_cell

module prpd_median #(
	parameter int unsigned DEPTH = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DEPTH*16-1:0]   hist,
	output logic                  done,
	output logic [15:0]           median
);
	import prpd_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [15:0] v [DEPTH];
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			prpd_sort_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.load      (start),
				.load_val  (hist[g*16 +: 16]),
				.step      (busy_q),
				.odd_phase (cnt_q[0]),
				.pair_lo   ((g % 2) == 0),
				.left_val  (v[(g == 0) ? 0 : g - 1]),
				.right_val (v[(g == DEPTH - 1) ? g : g + 1]),
				.has_left  (g != 0),
				.has_right (g != DEPTH - 1),
				.val       (v[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(DEPTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign done   = done_q;
	assign median = v[DEPTH/2];
endmodule

// ===== rtl/core/prpd_divider.sv =====
// prpd_divider: restoring divider for the rate, one quotient bit a cycle
// depends on prpd_pkg

module prpd_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import prpd_pkg::*;

	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q[15:0], quo_q[31]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				if (!diff[17]) begin
					rem_q <= diff[16:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for pulse_rate_peak_detector_core
// drives sample words with a table and pulse waves, checks every result word
// against the table or the predictor; depends on prpd_pkg and the core rtl
`timescale 1ns / 100ps

module tb_top;
	import prpd_pkg::*;

	localparam int unsigned HIST = 7;
	localparam int unsigned LIMIT = 600000;

	typedef struct packed {
		logic [1:0] st;
		logic [7:0] bpm;
		logic       fp;
	} pulse_word_t;

	typedef struct {
		logic [23:0] s;
		logic [31:0] t;
		bit          typed;
		pulse_word_t w;
	} table_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [23:0] ac_sample = '0;
	logic [31:0] time_ms = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] status;
	logic [7:0] rate_bpm;
	logic finger_present;
	logic cfg_we = 0;
	logic [IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	pulse_rate_peak_detector_core dut (.*);

	initial forever #5 clk = ~clk;

	// predictor state
	logic [31:0] regs [NUM_REGS];
	longint unsigned amp_avg;
	bit fing, hold_cnt, seek, lp_valid, ravg_valid;
	logic [31:0] hold_t0, on_t, lp_t;
	longint pk_lvl, prev_x, cand;
	int unsigned ign_cnt, iv_cnt;
	logic [15:0] hist [HIST];
	logic [31:0] ravg;

	pulse_word_t rate_words [$];
	int errors = 0;
	int cycles = 0;
	int idle_mode = 0;

	function automatic void clear_peaks();
		hold_cnt = 0;
		hold_t0 = 0;
		seek = 1;
		pk_lvl = longint'(regs[REG_START_THR]) * 4;
		lp_t = 0;
		lp_valid = 0;
		ign_cnt = 0;
		iv_cnt = 0;
		ravg = 0;
		ravg_valid = 0;
	endfunction

	function automatic logic [15:0] median_of_hist();
		logic [15:0] s [HIST];
		logic [15:0] k;
		int j;
		for (int i = 0; i < HIST; i++) s[i] = hist[i];
		for (int i = 1; i < HIST; i++) begin
			k = s[i];
			j = i;
			while (j > 0 && s[j-1] > k) begin
				s[j] = s[j-1];
				j--;
			end
			s[j] = k;
		end
		return s[HIST/2];
	endfunction

	function automatic pulse_word_t detect_pulse(logic [23:0] raw, logic [31:0] now);
		longint x, thr;
		longint unsigned ax;
		logic [31:0] dt, m, r, q;
		pulse_word_t w;
		x = longint'($signed(raw));
		ax = x < 0 ? -x : x;
		w.st = ST_NO_RATE;
		w.bpm = 0;
		amp_avg = (19 * amp_avg + (ax << 8) + 10) / 20;
		if (!fing) begin
			if (amp_avg > (64'(regs[REG_AMP_ON]) << 8)) begin
				if (!hold_cnt) begin
					hold_cnt = 1;
					hold_t0 = now;
				end
				if (now - hold_t0 >= regs[REG_HOLD_ON]) begin
					fing = 1;
					on_t = now;
					prev_x = 0;
					clear_peaks();
				end
			end else hold_cnt = 0;
		end else begin
			if (amp_avg < (64'(regs[REG_AMP_OFF]) << 8)) begin
				if (!hold_cnt) begin
					hold_cnt = 1;
					hold_t0 = now;
				end
				if (now - hold_t0 >= regs[REG_HOLD_OFF]) begin
					fing = 0;
					clear_peaks();
				end
			end else hold_cnt = 0;
		end
		if (!fing) w.st = ST_NO_FINGER;
		else if (now - on_t < regs[REG_WARMUP]) w.st = ST_WARMING;
		else begin
			if (seek && x * 4 > pk_lvl && prev_x < x) begin
				cand = x;
				seek = 0;
			end
			if (!seek && x < prev_x) begin
				dt = lp_valid ? now - lp_t : 32'd0;
				thr = cand < 30 * 1024 ? 30 * 1024 : cand;
				seek = 1;
				if (lp_valid && dt < regs[REG_MIN_INT]) w.st = ST_WARMING;
				else begin
					lp_t = now;
					lp_valid = 1;
					pk_lvl = thr;
					if (ign_cnt < IGNORE_MAX) begin
						ign_cnt++;
						w.st = ST_WARMING;
					end else begin
						if (dt > 0) begin
							if (iv_cnt < HIST) begin
								hist[iv_cnt] = dt > 65535 ? 16'hFFFF : dt[15:0];
								iv_cnt++;
							end else begin
								for (int i = 0; i < HIST - 1; i++) hist[i] = hist[i+1];
								hist[HIST-1] = dt > 65535 ? 16'hFFFF : dt[15:0];
							end
						end
						if (iv_cnt >= HIST) begin
							m = median_of_hist();
							if (m == 0) m = 1;
							r = (RATE_NUM + m / 2) / m;
							if (r > 65535) r = 65535;
							if (!ravg_valid) begin
								ravg = r;
								ravg_valid = 1;
							end else ravg = (7 * ravg + 3 * r + 5) / 10;
							q = (ravg + 128) >> 8;
							w.bpm = q > 255 ? 8'd255 : q[7:0];
							w.st = ST_RATE;
						end
					end
				end
			end
		end
		prev_x = x;
		w.fp = fing;
		return w;
	endfunction

	task automatic write_regs(input logic [31:0] v [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1;
			cfg_index <= i[IDX_BITS-1:0];
			cfg_data <= v[i][CFG_BITS-1:0];
			regs[i] = v[i] & ((i == REG_AMP_ON || i == REG_AMP_OFF || i == REG_START_THR) ?
				32'h7FFFFF : 32'hFFFF);
			@(posedge clk);
		end
		// index past the last register is dropped
		cfg_index <= IDX_BITS'(NUM_REGS);
		cfg_data <= CFG_BITS'($urandom);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_word(input logic [23:0] s, input logic [31:0] t,
			input bit typed, input pulse_word_t tw);
		int gap;
		pulse_word_t w;
		gap = 0;
		if (idle_mode == 0 && $urandom_range(99) < 15) gap = $urandom_range(1, 4);
		if (idle_mode == 1 && $urandom_range(99) < 51) gap = $urandom_range(1, 4);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		ac_sample <= s;
		time_ms <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		w = detect_pulse(s, t);
		rate_words.push_back(typed ? tw : w);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (rate_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (idle_mode == 0) out_ready <= $urandom_range(99) >= 51;
		else if (idle_mode == 1) out_ready <= $urandom_range(99) >= 15;
		else out_ready <= 1;
	end

	always @(posedge clk) begin
		pulse_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (rate_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = rate_words.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
				if (rate_bpm !== e.bpm) begin
					$error("rate_bpm expected %0d actual %0d", e.bpm, rate_bpm);
					errors++;
				end
				if (finger_present !== e.fp) begin
					$error("finger_present expected %0d actual %0d", e.fp, finger_present);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// pulse phase: triangle wave with noise, quiet stretches and odd timestamps
	task automatic pulse_phase(input int n, input int amp, input int quiet_pct,
			inout logic [31:0] t);
		int per, pos, v;
		bit quiet;
		per = $urandom_range(10, 18);
		pos = 0;
		quiet = 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 3) quiet = $urandom_range(99) < quiet_pct;
			pos = (pos + 1) % per;
			v = (pos < per / 2 ? pos : per - pos) * 2 * amp / per - amp / 2;
			v += $signed($urandom_range(0, 400)) - 200;
			if (quiet) v = $signed($urandom_range(0, 200)) - 100;
			if ($urandom_range(99) < 4) v = $urandom;
			case ($urandom_range(99))
				0: t = t + 70000;
				1: t = t;
				2: t = $urandom;
				default: t = t + $urandom_range(15, 35);
			endcase
			send_word(v[23:0], t, 0, '0);
			if (i == n / 3) idle_mode = 1;
			if (i == 2 * n / 3) idle_mode = 2;
		end
	endtask

	initial begin
		automatic table_row_t tbl [] = '{
			'{24'h000000, 32'd0, 1, '{ST_NO_FINGER, 8'd0, 1'b0}},
			'{24'h7FFFFF, 32'd10, 1, '{ST_NO_FINGER, 8'd0, 1'b0}},
			'{24'h800000, 32'd20, 1, '{ST_NO_FINGER, 8'd0, 1'b0}},
			'{24'h004000, 32'd600, 0, '0},
			'{24'h008000, 32'd900, 0, '0},
			'{24'hFF0000, 32'd2700, 0, '0},
			'{24'h010000, 32'd2720, 0, '0},
			'{24'h020000, 32'd2740, 0, '0},
			'{24'h010000, 32'd2760, 0, '0},
			'{24'h020000, 32'd2800, 0, '0},
			'{24'h030000, 32'd3200, 0, '0},
			'{24'h010000, 32'd3400, 0, '0},
			'{24'h030000, 32'd3500, 0, '0},
			'{24'h040000, 32'd3600, 0, '0},
			'{24'h000100, 32'd4000, 0, '0},
			'{24'h050000, 32'hFFFFFFF0, 0, '0},
			'{24'h060000, 32'hFFFFFFF8, 0, '0},
			'{24'h010000, 32'h00000200, 0, '0},
			'{24'h000000, 32'h00000300, 0, '0},
			'{24'h000000, 32'h00900000, 0, '0},
			'{24'h000000, 32'h00900400, 0, '0}
		};
		automatic logic [31:0] cfg_a [NUM_REGS] = '{12800, 5120, 60, 60, 150, 250, 7680};
		automatic logic [31:0] cfg_lo [NUM_REGS] = '{0, 0, 0, 0, 0, 1, 0};
		automatic logic [31:0] cfg_hi [NUM_REGS] =
			'{8388607, 8388607, 65535, 65535, 65535, 65535, 8388607};
		automatic logic [31:0] cfg_d [NUM_REGS] = '{9000, 6000, 20, 0, 40, 180, 20000};
		logic [31:0] t;

		regs = '{12800, 5120, 500, 500, 2000, 300, 7680};
		amp_avg = 0;
		fing = 0;
		on_t = 0;
		prev_x = 0;
		cand = 0;
		for (int i = 0; i < HIST; i++) hist[i] = 0;
		clear_peaks();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (tbl[i]) send_word(tbl[i].s, tbl[i].t, tbl[i].typed, tbl[i].w);
		drain();

		t = 32'd100000;
		idle_mode = 0;
		write_regs(cfg_a);
		pulse_phase(190, 60000, 10, t);
		drain();
		idle_mode = 0;
		write_regs(cfg_lo);
		pulse_phase(180, 60000, 20, t);
		drain();
		idle_mode = 0;
		write_regs(cfg_hi);
		pulse_phase(40, 8000000, 50, t);
		drain();
		idle_mode = 0;
		write_regs(cfg_d);
		pulse_phase(120, 50000, 40, t);
		drain();

		repeat (60) @(posedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule

// ===== pulse_rate_peak_detector_core.f =====
rtl/core/prpd_pkg.sv
rtl/core/prpd_sort_cell.sv
rtl/core/prpd_median.sv
rtl/core/prpd_divider.sv
rtl/core/pulse_rate_peak_detector_core.sv
bench/tb_top.sv
